### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/uuidp_pkg.sv
`default_nettype none

package uuidp_pkg;

    localparam int UUID_BYTES = 16;
    localparam int COUNT_W    = $clog2(UUID_BYTES) + 1;
    localparam int INDEX_W    = $clog2(UUID_BYTES);

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;

    typedef enum logic [2:0] {
        FAULT_NONE  = 3'd0,
        FAULT_BRACE = 3'd1,
        FAULT_LONG  = 3'd2,
        FAULT_CHAR  = 3'd3,
        FAULT_SHORT = 3'd4
    } t_fault;

    // Character classification passed from the decoder to the parser.
    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_dash;
        logic       is_open;
        logic       is_close;
    } t_char_class;

endpackage

`default_nettype wire

### src/uuidp_in_if.sv
`default_nettype none

interface uuidp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       is_last;

    modport source (output valid, output text_char, output is_last, input ready);
    modport sink (input valid, input text_char, input is_last, output ready);
endinterface

`default_nettype wire

### src/uuidp_out_if.sv
`default_nettype none

interface uuidp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_high;
    logic [63:0] value_low;
    logic        ok;
    logic [2:0]  error_code;

    modport source (
        output valid, output value_high, output value_low, output ok, output error_code,
        input ready
    );
    modport sink (
        input valid, input value_high, input value_low, input ok, input error_code,
        output ready
    );
endinterface

`default_nettype wire

### src/uuidp_in_stage.sv
`default_nettype none

module uuidp_in_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    uuidp_in_if.sink   i_in,
    input  wire logic  i_take,
    output logic       o_valid,
    output logic [7:0] o_char,
    output logic       o_last
);
    import uuidp_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       w_accept;

    // The register frees up in the same cycle that the parser consumes it.
    assign i_in.ready = !r_valid || i_take;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= i_in.text_char;
            r_last <= i_in.is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

`default_nettype wire

### src/uuidp_decode.sv
`default_nettype none

module uuidp_decode (
    input  wire logic [7:0]        i_char,
    output uuidp_pkg::t_char_class o_class
);
    import uuidp_pkg::*;

    logic w_digit;
    logic w_lower;
    logic w_upper;

    assign w_digit = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign w_lower = (i_char >= 8'h61) && (i_char <= 8'h66);
    assign w_upper = (i_char >= 8'h41) && (i_char <= 8'h46);

    always_comb begin
        o_class.is_hex   = w_digit || w_lower || w_upper;
        // Letters of both cases have 1..6 in the low nibble, so adding 9 gives 10..15.
        o_class.nibble   = w_digit ? i_char[3:0] : (i_char[3:0] + 4'd9);
        o_class.is_dash  = (i_char == CH_DASH);
        o_class.is_open  = (i_char == CH_OPEN);
        o_class.is_close = (i_char == CH_CLOSE);
    end

endmodule

`default_nettype wire

### src/uuidp_parse.sv
`default_nettype none

module uuidp_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_last,
    input  wire uuidp_pkg::t_char_class i_class,
    output logic                   o_take,
    uuidp_out_if.source            o_out
);
    import uuidp_pkg::*;

    logic [7:0]         r_bytes [UUID_BYTES];
    logic [COUNT_W-1:0] r_count;
    logic               r_low_next;
    logic               r_braced;
    logic               r_at_start;
    t_fault             r_fault;

    logic [7:0]         n_bytes [UUID_BYTES];
    logic [COUNT_W-1:0] n_count;
    logic               n_low_next;
    logic               n_braced;
    t_fault             n_fault;
    t_fault             n_err;
    logic [63:0]        n_high;
    logic [63:0]        n_low;

    logic               r_out_valid;
    logic [63:0]        r_out_high;
    logic [63:0]        r_out_low;
    t_fault             r_out_err;

    logic               w_skip;
    logic               w_open_now;
    logic [INDEX_W-1:0] w_index;
    logic               w_emit;

    // A last character needs the result register free (or freeing this cycle).
    assign o_take  = i_valid && (!i_last || !r_out_valid || o_out.ready);
    assign w_emit  = o_take && i_last;
    assign w_index = r_count[INDEX_W-1:0];

    always_comb begin
        n_bytes    = r_bytes;
        n_count    = r_count;
        n_low_next = r_low_next;
        n_fault    = r_fault;
        w_open_now = r_at_start && i_class.is_open;
        n_braced   = r_braced || w_open_now;
        w_skip     = w_open_now || (i_last && n_braced);
        if (!w_skip && (r_fault == FAULT_NONE) && !i_class.is_dash) begin
            if (r_count >= COUNT_W'(UUID_BYTES)) begin
                n_fault = FAULT_LONG;
            end else if (!i_class.is_hex) begin
                n_fault = FAULT_CHAR;
            end else if (!r_low_next) begin
                n_bytes[w_index] = {i_class.nibble, 4'h0};
                n_low_next       = 1'b1;
            end else begin
                n_bytes[w_index] = {r_bytes[w_index][7:4], i_class.nibble};
                n_count          = r_count + COUNT_W'(1);
                n_low_next       = 1'b0;
            end
        end

        if (n_braced && !i_class.is_close) begin
            n_err = FAULT_BRACE;
        end else if (n_fault != FAULT_NONE) begin
            n_err = n_fault;
        end else if (n_count < COUNT_W'(UUID_BYTES)) begin
            n_err = FAULT_SHORT;
        end else begin
            n_err = FAULT_NONE;
        end

        n_high = '0;
        n_low  = '0;
        if (n_err == FAULT_NONE) begin
            for (int k = 0; k < UUID_BYTES / 2; k++) begin
                n_high[63 - 8*k -: 8] = n_bytes[k];
                n_low[63 - 8*k -: 8]  = n_bytes[k + UUID_BYTES / 2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_low_next <= 1'b0;
            r_braced   <= 1'b0;
            r_at_start <= 1'b1;
            r_fault    <= FAULT_NONE;
        end else if (w_emit) begin
            r_count    <= '0;
            r_low_next <= 1'b0;
            r_braced   <= 1'b0;
            r_at_start <= 1'b1;
            r_fault    <= FAULT_NONE;
        end else if (o_take) begin
            r_count    <= n_count;
            r_low_next <= n_low_next;
            r_braced   <= n_braced;
            r_at_start <= 1'b0;
            r_fault    <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bytes <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_high <= n_high;
            r_out_low  <= n_low;
            r_out_err  <= n_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.value_high = r_out_high;
    assign o_out.value_low  = r_out_low;
    assign o_out.ok         = (r_out_err == FAULT_NONE);
    assign o_out.error_code = r_out_err;

endmodule

`default_nettype wire

### src/uuid_text_parser.sv
// Streaming UUID text parser. Characters arrive one per beat on i_in, with is_last set on the
// final character of each string; exactly one result beat leaves on o_out per string, after
// its last character. A leading '{' opens braces and then the string must end in '}'; dashes
// are ignored anywhere; hex digits of either case pack high nibble first into 16 bytes,
// returned as value_high (bytes 0 to 7) and value_low (bytes 8 to 15). On error both values
// are zero, ok is low and error_code says why: 1 missing closing brace, 2 too long, 3 bad
// character, 4 too short, with that priority except that of too long and bad character the
// one seen first wins. Throughput is one character per clock except during the stall below. A
// last character passes through the input register and then into the result register.
// The single result register sets the only stall: a last character waits in the input
// register while the previous result has not been taken, and the characters behind it
// wait on i_in meanwhile.
`default_nettype none

module uuid_text_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    uuidp_in_if.sink    i_in,
    uuidp_out_if.source o_out
);
    import uuidp_pkg::*;

    logic        w_valid;
    logic [7:0]  w_char;
    logic        w_last;
    logic        w_take;
    t_char_class w_class;

    // Input register: holds one character until the parser consumes it.
    uuidp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_char  (w_char),
        .o_last  (w_last)
    );

    // Classify the registered character: hex value, dash, braces.
    uuidp_decode u_decode (
        .i_char  (w_char),
        .o_class (w_class)
    );

    // Parser state, byte store and the result register.
    uuidp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_last  (w_last),
        .i_class (w_class),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### src/uuidp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module uuidp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_value_high,
    input wire logic [63:0] i_value_low,
    input wire logic        i_ok,
    input wire logic [2:0]  i_error_code
);
    import uuidp_pkg::*;

    `ASSERT_IMPLY(a_ok_matches_code, i_clk, i_rst_n, i_out_valid, i_ok == (i_error_code == FAULT_NONE))
    `ASSERT_IMPLY(a_code_known, i_clk, i_rst_n, i_out_valid, i_error_code <= FAULT_SHORT)
    `ASSERT_IMPLY(a_zero_on_error, i_clk, i_rst_n, i_out_valid && !i_ok, (i_value_high == 64'd0) && (i_value_low == 64'd0))
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_error_code) && $stable(i_value_high) && $stable(i_value_low))

endmodule

bind uuid_text_parser uuidp_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_value_high (o_out.value_high),
    .i_value_low  (o_out.value_low),
    .i_ok         (o_out.ok),
    .i_error_code (o_out.error_code)
);

`default_nettype wire

### dv/tb_uuid_text_parser.sv
`timescale 1ns / 1ps

module tb_uuid_text_parser;
    import uuidp_pkg::*;

    // The run is ended by force once the clock count reaches this limit.
    localparam int CYCLE_LIMIT = 200000;

    // Each random phase queues strings until it has at least this many characters.
    localparam int PHASE_CHARS = 800;

    // The receiver holds off completely during this window of its own cycle count, while the
    // sender keeps pushing strings, so a last character ends up parked in the input register.
    localparam int HOLD_START = 400;
    localparam int HOLD_END   = 800;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_beat;

    typedef struct packed {
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic        ok;
        t_fault      error_code;
    } t_uuid_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    uuidp_in_if  in_bus ();
    uuidp_out_if out_bus ();

    uuid_text_parser uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #1 clk = ~clk;

    // Characters waiting to be sent, and the string under construction before it is queued.
    t_text_beat   text_beats[$];
    logic [7:0]   draft_text[$];

    // Parsed UUIDs that the block still owes us, oldest first.
    t_uuid_result parsed_uuids[$];

    int fail_count = 0;
    int result_count = 0;
    int cycle_count = 0;

    // Shadow copy of the parser's per-string state.
    logic [7:0] uuid_bytes[UUID_BYTES];
    logic [4:0] byte_total;
    logic       half_byte;
    logic       in_braces;
    logic       first_char;
    t_fault     string_fault;

    function automatic void clear_parse_state();
        for (int i = 0; i < UUID_BYTES; i++) uuid_bytes[i] = 8'h00;
        byte_total   = '0;
        half_byte    = 1'b0;
        in_braces    = 1'b0;
        first_char   = 1'b1;
        string_fault = FAULT_NONE;
    endfunction

    // Value 0 to 15 for a hex digit of either case, 16 for any other character.
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return 5'(ch - "0");
        if (ch >= "a" && ch <= "f") return 5'(ch - "a" + 8'd10);
        if (ch >= "A" && ch <= "F") return 5'(ch - "A" + 8'd10);
        return 5'd16;
    endfunction

    // Advances the shadow parser by one accepted character. On the last character of a
    // string it works out the one result that string produces and queues it.
    function automatic void parse_beat(input logic [7:0] ch, input logic last);
        logic         skip;
        logic [4:0]   nib;
        t_fault       verdict;
        t_uuid_result res;

        skip = 1'b0;
        // Only a brace in the very first position opens a braced string, and that brace
        // is never content.
        if (first_char) begin
            first_char = 1'b0;
            if (ch == CH_OPEN) begin
                in_braces = 1'b1;
                skip = 1'b1;
            end
        end
        // The closing position of a braced string is never content either, whatever it holds.
        if (last && in_braces) skip = 1'b1;

        // Once a content fault is latched, the rest of the string is ignored. Dashes are
        // dropped anywhere. Anything past the sixteenth byte is too long, even a bad
        // character, and too long is checked before the digit itself.
        if (!skip && string_fault == FAULT_NONE && ch != CH_DASH) begin
            nib = hex_value(ch);
            if (byte_total >= UUID_BYTES) begin
                string_fault = FAULT_LONG;
            end else if (nib[4]) begin
                string_fault = FAULT_CHAR;
            end else if (!half_byte) begin
                uuid_bytes[byte_total[3:0]] = {nib[3:0], 4'h0};
                half_byte = 1'b1;
            end else begin
                uuid_bytes[byte_total[3:0]][3:0] = nib[3:0];
                byte_total = byte_total + 5'd1;
                half_byte = 1'b0;
            end
        end

        if (last) begin
            // A missing closing brace outranks everything, then the first content fault,
            // then a short count. A dangling half byte does not count as a byte.
            if (in_braces && ch != CH_CLOSE) verdict = FAULT_BRACE;
            else if (string_fault != FAULT_NONE) verdict = string_fault;
            else if (byte_total < UUID_BYTES) verdict = FAULT_SHORT;
            else verdict = FAULT_NONE;

            res.value_high = '0;
            res.value_low  = '0;
            if (verdict == FAULT_NONE) begin
                for (int i = 0; i < 8; i++) begin
                    res.value_high = {res.value_high[55:0], uuid_bytes[i]};
                    res.value_low  = {res.value_low[55:0], uuid_bytes[i + 8]};
                end
            end
            res.ok = (verdict == FAULT_NONE);
            res.error_code = verdict;
            parsed_uuids.push_back(res);
            clear_parse_state();
        end
    endfunction

    function automatic void flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endfunction

    // Hex digit character for n, upper or lower case picked at random.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'("0" + n);
        if ($urandom_range(0, 1) == 1) return 8'("A" + n - 4'd10);
        return 8'("a" + n - 4'd10);
    endfunction

    // Any byte that is neither a hex digit nor a dash, braces included.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (hex_value(c) < 5'd16 || c == CH_DASH);
        return c;
    endfunction

    // Appends hex digits to the draft, with dashes in the usual 8-4-4-4-12 spots if asked.
    function automatic void add_hex(input int digits, input bit dashed);
        for (int i = 0; i < digits; i++) begin
            if (dashed && (i == 8 || i == 12 || i == 16 || i == 20))
                draft_text.push_back(CH_DASH);
            draft_text.push_back(hex_char(4'($urandom_range(0, 15))));
        end
    endfunction

    // Moves the draft string into the send queue, flagging its final character.
    function automatic int queue_draft();
        t_text_beat beat;
        for (int i = 0; i < draft_text.size(); i++) begin
            beat.ch   = draft_text[i];
            beat.last = (i == draft_text.size() - 1);
            text_beats.push_back(beat);
        end
        return draft_text.size();
    endfunction

    function automatic void queue_text(input string s);
        draft_text.delete();
        for (int i = 0; i < s.len(); i++) draft_text.push_back(s[i]);
        void'(queue_draft());
    endfunction

    // Builds one random string in the draft. Most are well-formed or nearly so, since only
    // those reach the full byte count; the rest are short noise strings.
    function automatic void build_random_text();
        int kind;
        int spot;
        bit wrap;

        draft_text.delete();
        kind = $urandom_range(0, 99);
        wrap = 1'($urandom_range(0, 1));
        if (kind < 35) begin
            // Canonical form.
            add_hex(32, 1'b1);
        end else if (kind < 50) begin
            // All 32 digits with dashes scattered anywhere, including the ends.
            for (int i = 0; i < 32; i++) begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 2)) draft_text.push_back(CH_DASH);
                add_hex(1, 1'b0);
            end
            if ($urandom_range(0, 3) == 0) draft_text.push_back(CH_DASH);
        end else if (kind < 60) begin
            // Too many digits, sometimes followed by a bad character that must not win.
            add_hex(int'($urandom_range(33, 40)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0) begin
                draft_text.push_back(junk_char());
                add_hex(int'($urandom_range(0, 4)), 1'b0);
            end
        end else if (kind < 68) begin
            // Too few digits, most often 30 or 31.
            if ($urandom_range(0, 3) == 0) add_hex(int'($urandom_range(0, 31)), 1'b1);
            else add_hex(31 - int'($urandom_range(0, 1)), 1'b1);
        end else if (kind < 80) begin
            // One bad character somewhere in a full UUID, sometimes with extra digits after it.
            add_hex(32, 1'b1);
            spot = $urandom_range(0, draft_text.size() - 1);
            draft_text[spot] = junk_char();
            if ($urandom_range(0, 3) == 0) add_hex(int'($urandom_range(1, 6)), 1'b0);
        end else if (kind < 88) begin
            // Opening brace, mostly with no matching close at the end.
            wrap = 1'b0;
            draft_text.push_back(CH_OPEN);
            add_hex(32, 1'b1);
            case ($urandom_range(0, 2))
                0: ;
                1: draft_text.push_back(junk_char());
                default: draft_text.push_back($urandom_range(0, 1) ? CH_OPEN : CH_DASH);
            endcase
        end else begin
            // Short noise over the whole byte range.
            wrap = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 3))
                    0: draft_text.push_back(8'($urandom_range(0, 255)));
                    1: draft_text.push_back(hex_char(4'($urandom_range(0, 15))));
                    2: draft_text.push_back(CH_DASH);
                    default: draft_text.push_back($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
                endcase
            end
        end
        if (wrap) begin
            draft_text.push_front(CH_OPEN);
            draft_text.push_back(CH_CLOSE);
        end
        if (draft_text.size() == 0) draft_text.push_back(CH_DASH);
    endfunction

    // Blocks until every queued character has been taken and every result has come back.
    // The check runs on the falling edge so it never races the clocked processes.
    task automatic wait_drained();
        while (text_beats.size() != 0 || in_bus.valid || parsed_uuids.size() != 0)
            @(negedge clk);
    endtask

    // Sender. It offers characters in bursts of random length separated by random gaps,
    // and some bursts follow straight on from the previous one. A character, once offered,
    // stays on the bus until it is taken. Each accepted beat feeds the shadow parser.
    int gap_left = 0;
    int burst_left = 1;

    always @(posedge clk) begin : sender
        t_text_beat next_beat;
        if (!rst_n) begin
            in_bus.valid     <= 1'b0;
            in_bus.text_char <= 8'h00;
            in_bus.is_last   <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                parse_beat(in_bus.text_char, in_bus.is_last);
            if (!in_bus.valid || in_bus.ready) begin
                if (gap_left > 0) begin
                    in_bus.valid <= 1'b0;
                    gap_left = gap_left - 1;
                end else if (text_beats.size() > 0) begin
                    next_beat = text_beats.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.text_char <= next_beat.ch;
                    in_bus.is_last   <= next_beat.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Its ready pattern cycles through four modes in turn: always ready, mostly
    // ready, mostly stalled and a fixed on-off rhythm. One long hold-off window is laid over
    // that.
    int rx_cycle = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_END) begin
                out_bus.ready <= 1'b0;
            end else begin
                case ((rx_cycle / 256) % 4)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= ($urandom_range(0, 99) < 70);
                    2: out_bus.ready <= ($urandom_range(0, 99) < 30);
                    default: out_bus.ready <= ((rx_cycle % 8) < 3);
                endcase
            end
        end
    end

    // Result checker. Every result beat must match the oldest parsed UUID still owed.
    always @(posedge clk) begin : result_check
        t_uuid_result want;
        string        got_text;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            got_text = $sformatf("hi=%h lo=%h ok=%b code=%0d", out_bus.value_high,
                out_bus.value_low, out_bus.ok, out_bus.error_code);
            if (parsed_uuids.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing expected: %s",
                    result_count, got_text));
            end else begin
                want = parsed_uuids.pop_front();
                if (out_bus.value_high !== want.value_high
                        || out_bus.value_low !== want.value_low
                        || out_bus.ok !== want.ok
                        || out_bus.error_code !== want.error_code) begin
                    flag_mismatch($sformatf(
                        "result %0d: expected hi=%h lo=%h ok=%b code=%0d, got %s",
                        result_count, want.value_high, want.value_low, want.ok,
                        want.error_code, got_text));
                end
            end
            result_count++;
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL uuid_text_parser");
            $finish;
        end
    end

    // Stimulus. A short directed set of strings comes first, then two random phases. The
    // sender runs dry and waits for every result between phases, so the block is seen going
    // idle and starting again from a clean state.
    initial begin : stimulus
        int phase_chars;

        clear_parse_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Lone opening brace, empty braces, and a closing brace with no opening one.
        queue_text("{");
        queue_text("{}");
        queue_text("}");
        // The extreme character codes as one-character strings.
        draft_text.delete();
        draft_text.push_back(8'hFF);
        void'(queue_draft());
        draft_text.delete();
        draft_text.push_back(8'h00);
        void'(queue_draft());
        // A dash alone, a bad character inside braces, braces left open, a bad character
        // after mixed-case digits, and a bad character on its own.
        queue_text("-");
        queue_text("{x}");
        queue_text("{ab");
        queue_text("aF9-g");
        queue_text("Z");
        wait_drained();

        repeat (2) begin
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS) begin
                build_random_text();
                phase_chars += queue_draft();
            end
            wait_drained();
        end

        // Let the clock run on so that any stray result is caught.
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS uuid_text_parser");
        else
            $display("FAIL uuid_text_parser");
        $finish;
    end

endmodule

### uuid_text_parser.f
+incdir+src
src/uuidp_pkg.sv
src/uuidp_in_if.sv
src/uuidp_out_if.sv
src/uuidp_in_stage.sv
src/uuidp_decode.sv
src/uuidp_parse.sv
src/uuid_text_parser.sv
src/uuidp_checker.sv
dv/tb_uuid_text_parser.sv
